// ===== sv/secb_pkg.sv =====
// Package for the segment end-point clip block.
// Holds the item and result types, clip bounds and the back-end state codes.
`timescale 1ns / 1ps

package secb_pkg;

    localparam logic signed [31:0] CLIP_LO = -32'sd32752;   // -0x7FF0
    localparam logic signed [31:0] CLIP_HI = 32'sd32751;    //  0x7FEF
    localparam logic [31:0]        LEN_FORCE = 32'hFFFF_FFFF;
    localparam int                 FIFO_DEPTH = 4;

    typedef struct packed {
        logic [31:0] sx;      // start points, sign extended
        logic [31:0] sy;
        logic [31:0] sz;
        logic [31:0] ex;
        logic [31:0] ey;
        logic [31:0] ez;
        logic [31:0] len;
        logic        force_len;
    } t_item;

    typedef struct packed {
        logic [15:0] clip_x;
        logic [15:0] clip_y;
        logic [15:0] clip_z;
        logic [31:0] len_out;
        logic        div_zero;
    } t_result;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AXIS,
        ST_MUL,
        ST_DIVI,
        ST_DIV,
        ST_WB,
        ST_SQ,
        ST_ACC,
        ST_ROOT,
        ST_LEN,
        ST_DONE
    } t_state;

    function automatic logic [31:0] asr4(input logic [31:0] v);
        asr4 = {{4{v[31]}}, v[31:4]};
    endfunction

endpackage

// ===== sv/secb_front.sv =====
// Front end of the clip block: accepts items, classifies them and queues them.
// Depends on secb_pkg.
`timescale 1ns / 1ps

module secb_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic [15:0]          i_start_x,
    input  logic [15:0]          i_start_y,
    input  logic [15:0]          i_start_z,
    input  logic [31:0]          i_end_x,
    input  logic [31:0]          i_end_y,
    input  logic [31:0]          i_end_z,
    input  logic [31:0]          i_len_in,
    output logic                 o_valid,
    input  logic                 i_take,
    output secb_pkg::t_item      o_item
);

    secb_pkg::t_item r_mem [secb_pkg::FIFO_DEPTH];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       w_wr, w_rd;
    secb_pkg::t_item w_new;

    assign o_full  = (r_cnt == 3'(secb_pkg::FIFO_DEPTH));
    assign o_valid = (r_cnt != 3'd0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_take && o_valid;
    assign o_item  = r_mem[r_rp];

    always_comb begin
        w_new.sx = {{16{i_start_x[15]}}, i_start_x};
        w_new.sy = {{16{i_start_y[15]}}, i_start_y};
        w_new.sz = {{16{i_start_z[15]}}, i_start_z};
        w_new.ex = i_end_x;
        w_new.ey = i_end_y;
        w_new.ez = i_end_z;
        w_new.len = i_len_in;
        w_new.force_len = (i_len_in == secb_pkg::LEN_FORCE);
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= r_wp + 2'd1;
            if (w_rd) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(w_wr) - 3'(w_rd);
        end
    end

endmodule

// ===== sv/secb_back.sv =====
// Back end of the clip block: per-axis clip with a shared multiplier and
// radix-2 divider, then a digit-serial square root; holds one result.
// Depends on secb_pkg.
`timescale 1ns / 1ps

module secb_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_take,
    input  secb_pkg::t_item      i_item,
    output logic                 o_empty,
    input  logic                 i_pop,
    output secb_pkg::t_result    o_res
);

    secb_pkg::t_state r_state, n_state;

    logic [31:0] r_s [3];
    logic [31:0] r_c [3];
    logic [31:0] r_len;
    logic        r_force, r_dz, r_clip;
    logic [1:0]  r_a, r_k;
    logic [31:0] r_mul, r_den, r_prod, r_sum;
    logic [31:0] r_dvd, r_dvs;
    logic [31:0] r_rem;
    logic        r_neg;
    logic [4:0]  r_cnt;
    logic [31:0] r_sv;
    logic [15:0] r_root;
    logic [17:0] r_srem;
    logic        r_out_valid;
    secb_pkg::t_result r_res;

    logic [31:0] w_old, w_sa, w_ck, w_sk, w_bound, w_d;
    logic        w_lo, w_hi, w_clip_now;
    logic [1:0]  w_nk, w_first_k;
    logic        w_last_k, w_out_free, w_need_len;
    logic [32:0] w_rem_sh;
    logic [19:0] w_srem_sh, w_trial;
    logic [31:0] w_q;

    assign w_out_free = !r_out_valid || i_pop;
    assign w_need_len = r_clip || r_force;

    always_comb begin
        w_old = r_c[0];
        w_sa  = r_s[0];
        unique case (r_a)
            2'd1:    begin w_old = r_c[1]; w_sa = r_s[1]; end
            2'd2:    begin w_old = r_c[2]; w_sa = r_s[2]; end
            default: begin w_old = r_c[0]; w_sa = r_s[0]; end
        endcase
        w_ck = r_c[0];
        w_sk = r_s[0];
        unique case (r_k)
            2'd1:    begin w_ck = r_c[1]; w_sk = r_s[1]; end
            2'd2:    begin w_ck = r_c[2]; w_sk = r_s[2]; end
            default: begin w_ck = r_c[0]; w_sk = r_s[0]; end
        endcase
        w_lo = $signed(w_old) < secb_pkg::CLIP_LO;
        w_hi = $signed(w_old) > secb_pkg::CLIP_HI;
        w_clip_now = w_lo || w_hi;
        w_bound = w_lo ? secb_pkg::CLIP_LO : secb_pkg::CLIP_HI;
        w_first_k = (r_a == 2'd0) ? 2'd1 : 2'd0;
        // next other axis, skipping the one being clipped
        w_nk = r_k + 2'd1;
        if (w_nk == r_a) w_nk = w_nk + 2'd1;
        w_last_k = (r_k == 2'd2) || (r_k == 2'd1 && r_a == 2'd2);
        w_d = secb_pkg::asr4(w_ck - w_sk);
        w_rem_sh  = {r_rem, r_dvd[31]};
        w_srem_sh = {r_srem, r_sv[31:30]};
        w_trial   = {2'b00, r_root, 2'b01};
        w_q = r_neg ? (32'd0 - r_dvd) : r_dvd;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            secb_pkg::ST_IDLE: if (i_valid) n_state = secb_pkg::ST_AXIS;
            secb_pkg::ST_AXIS: begin
                if (w_clip_now) n_state = secb_pkg::ST_MUL;
                else if (r_a == 2'd2) n_state = secb_pkg::ST_SQ;
            end
            secb_pkg::ST_MUL:  n_state = secb_pkg::ST_DIVI;
            secb_pkg::ST_DIVI: begin
                if (r_den != 32'd0) n_state = secb_pkg::ST_DIV;
                else if (!w_last_k) n_state = secb_pkg::ST_MUL;
                else if (r_a == 2'd2) n_state = secb_pkg::ST_SQ;
                else n_state = secb_pkg::ST_AXIS;
            end
            secb_pkg::ST_DIV:  if (r_cnt == 5'd31) n_state = secb_pkg::ST_WB;
            secb_pkg::ST_WB: begin
                if (!w_last_k) n_state = secb_pkg::ST_MUL;
                else if (r_a == 2'd2) n_state = secb_pkg::ST_SQ;
                else n_state = secb_pkg::ST_AXIS;
            end
            secb_pkg::ST_SQ:   n_state = w_need_len ? secb_pkg::ST_ACC : secb_pkg::ST_DONE;
            secb_pkg::ST_ACC:  n_state = (r_k == 2'd2) ? secb_pkg::ST_ROOT : secb_pkg::ST_SQ;
            secb_pkg::ST_ROOT: if (r_cnt == 5'd15) n_state = secb_pkg::ST_LEN;
            secb_pkg::ST_LEN:  n_state = secb_pkg::ST_DONE;
            secb_pkg::ST_DONE: if (w_out_free) n_state = secb_pkg::ST_IDLE;
            default:           n_state = secb_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_take  = (r_state == secb_pkg::ST_IDLE) && i_valid;
        o_empty = !r_out_valid;
        o_res   = r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= secb_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == secb_pkg::ST_DONE && w_out_free) r_out_valid <= 1'b1;
            else if (i_pop) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            secb_pkg::ST_IDLE: begin
                r_s[0] <= i_item.sx;  r_s[1] <= i_item.sy;  r_s[2] <= i_item.sz;
                r_c[0] <= i_item.ex;  r_c[1] <= i_item.ey;  r_c[2] <= i_item.ez;
                r_len <= i_item.len;
                r_force <= i_item.force_len;
                r_dz <= 1'b0;
                r_clip <= 1'b0;
                r_a <= 2'd0;
            end
            secb_pkg::ST_AXIS: begin
                if (w_clip_now) begin
                    r_c[r_a] <= w_bound;
                    r_mul <= secb_pkg::asr4(w_bound - w_sa);
                    r_den <= secb_pkg::asr4(w_old - w_sa);
                    r_clip <= 1'b1;
                    r_k <= w_first_k;
                end else if (r_a == 2'd2) begin
                    r_k <= 2'd0;
                    r_sum <= '0;
                end else begin
                    r_a <= r_a + 2'd1;
                end
            end
            secb_pkg::ST_MUL: r_prod <= 32'((w_ck - w_sk) * r_mul);
            secb_pkg::ST_DIVI: begin
                if (r_den != 32'd0) begin
                    r_dvd <= r_prod[31] ? (32'd0 - r_prod) : r_prod;
                    r_dvs <= r_den[31] ? (32'd0 - r_den) : r_den;
                    r_rem <= '0;
                    r_neg <= r_prod[31] ^ r_den[31];
                    r_cnt <= '0;
                end else begin
                    r_c[r_k] <= w_sk;
                    r_dz <= 1'b1;
                    if (!w_last_k) r_k <= w_nk;
                    else if (r_a == 2'd2) begin r_k <= 2'd0; r_sum <= '0; end
                    else r_a <= r_a + 2'd1;
                end
            end
            secb_pkg::ST_DIV: begin
                // one quotient bit per cycle, shifted into the dividend register
                if (w_rem_sh >= {1'b0, r_dvs}) begin
                    r_rem <= 32'(w_rem_sh - {1'b0, r_dvs});
                    r_dvd <= {r_dvd[30:0], 1'b1};
                end else begin
                    r_rem <= w_rem_sh[31:0];
                    r_dvd <= {r_dvd[30:0], 1'b0};
                end
                r_cnt <= r_cnt + 5'd1;
            end
            secb_pkg::ST_WB: begin
                r_c[r_k] <= w_q + w_sk;
                if (!w_last_k) r_k <= w_nk;
                else if (r_a == 2'd2) begin r_k <= 2'd0; r_sum <= '0; end
                else r_a <= r_a + 2'd1;
            end
            secb_pkg::ST_SQ:  r_prod <= 32'(w_d * w_d);
            secb_pkg::ST_ACC: begin
                r_sum <= r_sum + r_prod;
                r_k <= r_k + 2'd1;
                if (r_k == 2'd2) begin
                    r_sv <= r_sum + r_prod;
                    r_root <= '0;
                    r_srem <= '0;
                    r_cnt <= '0;
                end
            end
            secb_pkg::ST_ROOT: begin
                // two radicand bits per cycle
                if (w_srem_sh >= w_trial) begin
                    r_srem <= 18'(w_srem_sh - w_trial);
                    r_root <= {r_root[14:0], 1'b1};
                end else begin
                    r_srem <= w_srem_sh[17:0];
                    r_root <= {r_root[14:0], 1'b0};
                end
                r_sv <= {r_sv[29:0], 2'b00};
                r_cnt <= r_cnt + 5'd1;
            end
            secb_pkg::ST_LEN: r_len <= {12'd0, r_root, 4'd0};
            secb_pkg::ST_DONE: begin
                if (w_out_free) begin
                    r_res.clip_x   <= r_c[0][15:0];
                    r_res.clip_y   <= r_c[1][15:0];
                    r_res.clip_z   <= r_c[2][15:0];
                    r_res.len_out  <= r_len;
                    r_res.div_zero <= r_dz;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== sv/segment_endpoint_clip_to_box.sv =====
// Top level of the segment end-point clip block.
// Depends on secb_pkg, secb_front and secb_back.
//
// Usage:
//   Input channel: drive start/end/len on i_* ports with i_push; an item
//   transfers on a clock edge with i_push high and o_full low. A four-entry
//   queue takes items back to back until it is full while the back end is busy.
//   Result channel: while o_empty is low the result ports hold the oldest
//   result; it transfers on an edge with i_pop high.
//   Timing: the back end runs one item at a time. An unclipped item with a
//   given length passes the take, three axis checks, a length step and the
//   result write; each clipped axis adds two 32-step divides, each with
//   multiply, setup and write-back (only multiply and setup when the divisor
//   is zero), and a length recompute adds three squares and a 16-step root.
//   The result register frees in the cycle it is popped, so a stalled
//   receiver only holds the back end, while the queue keeps accepting until full.
//   Reset (i_rst_n low, synchronous) empties queue and result register.
`timescale 1ns / 1ps

module segment_endpoint_clip_to_box (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [15:0] i_start_x,
    input  logic [15:0] i_start_y,
    input  logic [15:0] i_start_z,
    input  logic [31:0] i_end_x,
    input  logic [31:0] i_end_y,
    input  logic [31:0] i_end_z,
    input  logic [31:0] i_len_in,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [15:0] o_clip_x,
    output logic [15:0] o_clip_y,
    output logic [15:0] o_clip_z,
    output logic [31:0] o_len_out,
    output logic        o_div_zero
);

    logic              w_valid, w_take;
    secb_pkg::t_item   w_item;
    secb_pkg::t_result w_res;

    secb_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (i_push),
        .o_full    (o_full),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_start_z (i_start_z),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .i_end_z   (i_end_z),
        .i_len_in  (i_len_in),
        .o_valid   (w_valid),
        .i_take    (w_take),
        .o_item    (w_item)
    );

    secb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid),
        .o_take  (w_take),
        .i_item  (w_item),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_res   (w_res)
    );

    assign o_clip_x   = w_res.clip_x;
    assign o_clip_y   = w_res.clip_y;
    assign o_clip_z   = w_res.clip_z;
    assign o_len_out  = w_res.len_out;
    assign o_div_zero = w_res.div_zero;

endmodule
